// ----- rtl/box_blur_frame_query_defines.svh -----
// ----------------------------------------------------------------------------
// box_blur_frame_query_defines
// Assertion macros shared by the box blur frame query RTL.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_FRAME_QUERY_DEFINES_SVH
`define BOX_BLUR_FRAME_QUERY_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BBFQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BBFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bbfq_pkg.sv -----
// ----------------------------------------------------------------------------
// bbfq_pkg
// Types, widths and register codes of the box blur frame query block.
// ----------------------------------------------------------------------------
package bbfq_pkg;

  localparam int ChanW  = 8;
  localparam int PixW   = 3 * ChanW;
  localparam int CoordW = 10;
  localparam int CoordMax = (2 ** CoordW) - 1;
  localparam int WinW   = 5;
  localparam int DivW   = 2 * WinW;
  localparam int SumW   = DivW + ChanW;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 10;

  localparam int DefMaxWidth  = 512;
  localparam int DefMaxHeight = 512;
  localparam int DefMaxWindow = 31;

  localparam logic [CfgIdxW-1:0] CfgWindowSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd2;

  localparam logic [WinW-1:0]   RstWindowSize  = 5'd3;
  localparam logic [CoordW-1:0] RstImageWidth  = 10'd512;
  localparam logic [CoordW-1:0] RstImageHeight = 10'd512;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // lane 2 red, lane 1 green, lane 0 blue
  typedef logic [2:0][SumW-1:0]  rgb_sum_t;
  typedef logic [2:0][ChanW-1:0] rgb_pix_t;

endpackage

// ----- rtl/bbfq_div.sv -----
// ----------------------------------------------------------------------------
// bbfq_div
// Three-lane restoring divider with saturation at 255, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "box_blur_frame_query_defines.svh"

module bbfq_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bbfq_pkg::DivW-1:0]     divisor_i,
  input  bbfq_pkg::rgb_sum_t            sum_i,
  output logic                          done_o,
  output bbfq_pkg::rgb_pix_t            quot_o
);
  import bbfq_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_SAT  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [2:0]      bit_q;
  logic            done_q;
  logic [DivW-1:0] div_q;
  rgb_sum_t        rem_q, rem_d;
  rgb_pix_t        quo_q, res_q;
  logic [2:0]      sat_q, take;
  logic [SumW-1:0] trial;

  always_comb begin
    trial = SumW'(div_q) << bit_q;
    for (int k = 0; k < 3; k++) begin
      take[k]  = ~sat_q[k] && (rem_q[k] >= trial);
      rem_d[k] = take[k] ? rem_q[k] - trial : rem_q[k];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i) state_d = DV_SAT;
      DV_SAT:  state_d = DV_RUN;
      DV_RUN:  if (bit_q == '0) state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      bit_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == DV_RUN) && (bit_q == '0);
      if (state_q == DV_SAT) begin
        bit_q <= 3'd7;
      end else if (state_q == DV_RUN) begin
        bit_q <= bit_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          rem_q <= sum_i;
          div_q <= divisor_i;
        end
      end
      DV_SAT: begin
        for (int k = 0; k < 3; k++) begin
          sat_q[k] <= rem_q[k] >= SumW'({div_q, 8'b0});
        end
        quo_q <= '0;
      end
      DV_RUN: begin
        rem_q <= rem_d;
        for (int k = 0; k < 3; k++) begin
          quo_q[k][bit_q] <= take[k];
          if (bit_q == '0) begin
            res_q[k] <= sat_q[k] ? {ChanW{1'b1}} : {quo_q[k][ChanW-1:1], take[k]};
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = res_q;

  `BBFQ_ASSERT_NEXT(a_div_done, (state_q == DV_RUN) && (bit_q == '0), done_q, "divider missed done")
  `BBFQ_ASSERT_IMPL(a_div_start_idle, start_i, state_q == DV_IDLE, "divider started while busy")
  `BBFQ_ASSERT_NEXT(a_div_sat_run, state_q == DV_SAT, (state_q == DV_RUN) && (bit_q == 3'd7), "divider skipped top bit")

endmodule

// ----- rtl/box_blur_frame_query.sv -----
// ----------------------------------------------------------------------------
// box_blur_frame_query
// RGB frame store with box-blur queries over a clipped square window.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start_i while busy_o is low. kind_i = write stores the
//   pixel at (row_i, col_i) in the same edge; busy_o stays low, so writes
//   may follow each cycle. kind_i = query raises busy_o and walks the frame
//   store one pixel a cycle over the window clipped to the frame, then
//   divides by the window size squared (0 counts as 1), one quotient bit a
//   cycle for all three channels; an empty clipped window skips the walk.
//   A query keeps busy_o high until its result is on the blurred_*_o
//   ports for one cycle with result_valid_o high, in the last busy cycle.
//   The memory read port and the serial divider set the busy time.
//   Config writes go through cfg_valid_i / cfg_ready_o and are taken
//   always; change them only while idle.
//   Reset clears the registers to window 3, frame 512 x 512; the frame store
//   is not cleared and holds nothing defined until written. The receiver
//   cannot stall: each result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "box_blur_frame_query_defines.svh"

module box_blur_frame_query #(
  parameter int MAX_WIDTH  = bbfq_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = bbfq_pkg::DefMaxHeight,
  parameter int MAX_WINDOW = bbfq_pkg::DefMaxWindow
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           kind_i,
  input  logic [8:0]                     row_i,
  input  logic [8:0]                     col_i,
  input  logic [bbfq_pkg::ChanW-1:0]     pixel_red_i,
  input  logic [bbfq_pkg::ChanW-1:0]     pixel_green_i,
  input  logic [bbfq_pkg::ChanW-1:0]     pixel_blue_i,
  output logic                           result_valid_o,
  output logic [bbfq_pkg::ChanW-1:0]     blurred_red_o,
  output logic [bbfq_pkg::ChanW-1:0]     blurred_green_o,
  output logic [bbfq_pkg::ChanW-1:0]     blurred_blue_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbfq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bbfq_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bbfq_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int WCap  = (MAX_WIDTH  < CoordMax) ? MAX_WIDTH  : CoordMax;
  localparam int HCap  = (MAX_HEIGHT < CoordMax) ? MAX_HEIGHT : CoordMax;
  localparam logic [CoordW-1:0] WCapC   = CoordW'(WCap);
  localparam logic [CoordW-1:0] HCapC   = CoordW'(HCap);
  localparam logic [WinW:0]     MaxWinC = (WinW + 1)'(MAX_WINDOW);
  localparam logic [AW-1:0]     RowStep = AW'(MAX_WIDTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [WinW-1:0]   window_q;
  logic [CoordW-1:0] width_q, height_q;
  logic              rd_vld_q;

  logic [8:0]        row_q, col_q;
  logic [CoordW-1:0] r_q, c_q, c0_q, r1_q, c1_q;
  logic [DivW-1:0]   div_q;
  rgb_sum_t          sum_q;
  logic [PixW-1:0]   rd_data_q;
  logic [PixW-1:0]   frame_mem [Depth];

  logic              accept, wr_en, last_px;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WinW-1:0]   ws_nz, ws;
  logic [CoordW-1:0] reach, w_eff, h_eff, row_ext, col_ext;
  logic [CoordW-1:0] r0, r1, c0, c1, r_hi, c_hi;
  logic              empty;
  logic [DivW-1:0]   div_val;
  logic              div_done;
  rgb_pix_t          quot;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign wr_en       = accept && (kind_i == KindWrite) &&
                       (int'(row_i) < MAX_HEIGHT) && (int'(col_i) < MAX_WIDTH);
  assign wr_addr     = AW'(AW'(row_i) * RowStep + AW'(col_i));
  assign rd_addr     = AW'(AW'(r_q) * RowStep + AW'(c_q));
  assign last_px     = (r_q == r1_q) && (c_q == c1_q);

  // window bounds, clipped to the frame
  always_comb begin
    ws_nz   = (window_q == '0) ? WinW'(1) : window_q;
    ws      = ({1'b0, ws_nz} > MaxWinC) ? WinW'(MaxWinC) : ws_nz;
    reach   = CoordW'(ws >> 1);
    div_val = DivW'(ws) * DivW'(ws);
    w_eff   = (width_q  > WCapC) ? WCapC : width_q;
    h_eff   = (height_q > HCapC) ? HCapC : height_q;
    row_ext = CoordW'(row_q);
    col_ext = CoordW'(col_q);
    r0      = (row_ext > reach) ? row_ext - reach : '0;
    c0      = (col_ext > reach) ? col_ext - reach : '0;
    r_hi    = row_ext + reach;
    c_hi    = col_ext + reach;
    r1      = (r_hi > h_eff - CoordW'(1)) ? h_eff - CoordW'(1) : r_hi;
    c1      = (c_hi > w_eff - CoordW'(1)) ? w_eff - CoordW'(1) : c_hi;
    empty   = (w_eff == '0) || (h_eff == '0) || (r0 > r1) || (c0 > c1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept && (kind_i == KindQuery)) state_d = S_SETUP;
      S_SETUP:  state_d = empty ? S_LAUNCH : S_READ;
      S_READ:   if (last_px) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_LAUNCH;
      S_LAUNCH: state_d = S_WAIT;
      S_WAIT:   if (div_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_vld_q <= 1'b0;
      window_q <= RstWindowSize;
      width_q  <= RstImageWidth;
      height_q <= RstImageHeight;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_READ);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgWindowSize:  window_q <= cfg_data_i[WinW-1:0];
          CfgImageWidth:  width_q  <= cfg_data_i[CoordW-1:0];
          CfgImageHeight: height_q <= cfg_data_i[CoordW-1:0];
          default: ;
        endcase
      end
    end
  end

  // query datapath: window walk and accumulation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (state_q == S_SETUP) begin
      r_q   <= r0;
      c_q   <= c0;
      c0_q  <= c0;
      r1_q  <= r1;
      c1_q  <= c1;
      div_q <= div_val;
    end else if (state_q == S_READ) begin
      if (c_q == c1_q) begin
        c_q <= c0_q;
        r_q <= r_q + CoordW'(1);
      end else begin
        c_q <= c_q + CoordW'(1);
      end
    end
    if (state_q == S_SETUP) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SumW'(rd_data_q[k*ChanW +: ChanW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= {pixel_red_i, pixel_green_i, pixel_blue_i};
    end
    rd_data_q <= frame_mem[rd_addr];
  end

  bbfq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == S_LAUNCH),
    .divisor_i (div_q),
    .sum_i     (sum_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign result_valid_o  = div_done;
  assign blurred_red_o   = quot[2];
  assign blurred_green_o = quot[1];
  assign blurred_blue_o  = quot[0];

  `BBFQ_ASSERT_IMPL(a_result_in_wait, result_valid_o, state_q == S_WAIT, "result outside query")
  `BBFQ_ASSERT_IMPL(a_idle_no_read, !busy_o, !rd_vld_q, "read pending while idle")
  `BBFQ_ASSERT_IMPL(a_walk_bounds, state_q == S_READ, (r_q <= r1_q) && (c_q <= c1_q), "walk past window")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box blur frame query block. A local frame copy
// tracks every pixel write and predicts each blurred query result. The
// block's configuration is changed only between phases, while it is idle.
// Directed items cover frame corners, edge clipping, window modes and frame
// extremes. Random phases then fill each query window before querying it,
// so that no query reads a pixel that was never written.
// ----------------------------------------------------------------------------
module tb_top;
  import bbfq_pkg::*;

  localparam int FrameW       = DefMaxWidth;
  localparam int FrameH       = DefMaxHeight;
  localparam int HalfPeriod   = 5;
  localparam int MaxReported  = 10;
  localparam int TailCycles   = 1000;
  localparam int RunLimit     = 50_000_000;
  localparam int IdlePct      = 16;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                busy_o;
  logic                kind_i         = KindWrite;
  logic [8:0]          row_i          = '0;
  logic [8:0]          col_i          = '0;
  logic [ChanW-1:0]    pixel_red_i    = '0;
  logic [ChanW-1:0]    pixel_green_i  = '0;
  logic [ChanW-1:0]    pixel_blue_i   = '0;
  logic                result_valid_o;
  logic [ChanW-1:0]    blurred_red_o;
  logic [ChanW-1:0]    blurred_green_o;
  logic [ChanW-1:0]    blurred_blue_o;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  box_blur_frame_query i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .result_valid_o (result_valid_o),
    .blurred_red_o  (blurred_red_o),
    .blurred_green_o(blurred_green_o),
    .blurred_blue_o (blurred_blue_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  logic [PixW-1:0]   frame_mem [FrameW*FrameH];
  bit                written   [FrameW*FrameH];
  logic [WinW-1:0]   win_size  = RstWindowSize;
  logic [CoordW-1:0] img_w     = RstImageWidth;
  logic [CoordW-1:0] img_h     = RstImageHeight;

  rgb_pix_t blur_expected [$];
  rgb_pix_t blur_want;
  rgb_pix_t blur_got;
  int       blur_mismatches = 0;
  int       idle_pct        = IdlePct;
  int       sent_count      = 0;

  always #HalfPeriod clk_i = ~clk_i;

  function automatic int unsigned eff_window();
    int unsigned ws;
    ws = (win_size == '0) ? 1 : win_size;
    return (ws > DefMaxWindow) ? DefMaxWindow : ws;
  endfunction

  // window clipped to the frame; returns 0 when it holds no pixel
  function automatic bit clip_window(input int unsigned row, input int unsigned col,
                                     output int unsigned r0, output int unsigned r1,
                                     output int unsigned c0, output int unsigned c1);
    int unsigned reach, w, h;
    reach = eff_window() / 2;
    w  = (img_w < FrameW) ? img_w : FrameW;
    h  = (img_h < FrameH) ? img_h : FrameH;
    r0 = (row > reach) ? row - reach : 0;
    c0 = (col > reach) ? col - reach : 0;
    r1 = row + reach;
    c1 = col + reach;
    if (w == 0 || h == 0) return 1'b0;
    if (r1 > h - 1) r1 = h - 1;
    if (c1 > w - 1) c1 = w - 1;
    return (r0 <= r1) && (c0 <= c1);
  endfunction

  function automatic rgb_pix_t blur_predict(input int unsigned row, input int unsigned col);
    int unsigned r0, r1, c0, c1, r, c, dv, q;
    int unsigned acc [3];
    int          k;
    logic [PixW-1:0] p;
    rgb_pix_t    px;
    for (k = 0; k < 3; k++) acc[k] = 0;
    dv = eff_window() * eff_window();
    if (clip_window(row, col, r0, r1, c0, c1)) begin
      for (r = r0; r <= r1; r++) begin
        for (c = c0; c <= c1; c++) begin
          p = frame_mem[r*FrameW + c];
          for (k = 0; k < 3; k++) acc[k] += p[k*ChanW +: ChanW];
        end
      end
    end
    for (k = 0; k < 3; k++) begin
      q = acc[k] / dv;
      px[k] = (q > 255) ? 8'd255 : q[ChanW-1:0];
    end
    return px;
  endfunction

  // start stays high after acceptance; the next call or wait_idle moves it
  task automatic send_item(input logic kind, input logic [8:0] row, input logic [8:0] col,
                           input logic [PixW-1:0] pix);
    bit taken;
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    kind_i        <= kind;
    row_i         <= row;
    col_i         <= col;
    pixel_red_i   <= pix[2*ChanW +: ChanW];
    pixel_green_i <= pix[ChanW +: ChanW];
    pixel_blue_i  <= pix[0 +: ChanW];
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    sent_count++;
    if (kind == KindWrite) begin
      frame_mem[row*FrameW + col] = pix;
      written[row*FrameW + col]   = 1'b1;
    end else begin
      blur_expected.push_back(blur_predict(row, col));
    end
  endtask

  // fill every unwritten pixel of the clipped window, then query
  task automatic query_at(input int unsigned row, input int unsigned col);
    int unsigned r0, r1, c0, c1, r, c;
    if (clip_window(row, col, r0, r1, c0, c1)) begin
      for (r = r0; r <= r1; r++) begin
        for (c = c0; c <= c1; c++) begin
          if (!written[r*FrameW + c]) send_item(KindWrite, 9'(r), 9'(c), PixW'($urandom()));
        end
      end
    end
    send_item(KindQuery, 9'(row), 9'(col), PixW'($urandom()));
  endtask

  task automatic wait_idle();
    bit was_busy;
    bit quiet;
    start_i <= 1'b0;
    do begin
      @(negedge clk_i);
      was_busy = busy_o !== 1'b0;
      @(posedge clk_i);
      quiet = !was_busy && blur_expected.size() == 0;
    end while (!quiet);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o === 1'b1;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgWindowSize:  win_size = data[WinW-1:0];
      CfgImageWidth:  img_w    = data;
      CfgImageHeight: img_h    = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned ws, input int unsigned w, input int unsigned h);
    logic [CfgDataW-WinW-1:0] junk;
    junk = (CfgDataW - WinW)'($urandom());
    wait_idle();
    cfg_write(CfgWindowSize, {junk, ws[WinW-1:0]});
    cfg_write(CfgImageWidth, w[CfgDataW-1:0]);
    cfg_write(CfgImageHeight, h[CfgDataW-1:0]);
  endtask

  task automatic run_random(input int n_items, input int unsigned span);
    int          first;
    int unsigned row, col;
    first = sent_count;
    while (sent_count - first < n_items) begin
      if ($urandom_range(99, 0) < 20) begin
        row = $urandom_range(511, 0);
        col = $urandom_range(511, 0);
      end else begin
        row = $urandom_range(span - 1, 0);
        col = $urandom_range(span - 1, 0);
      end
      if ($urandom_range(99, 0) < 55) begin
        send_item(KindWrite, 9'(row), 9'(col), PixW'($urandom()));
      end else begin
        query_at(row, col);
      end
    end
  endtask

  task automatic test_corners();
    send_item(KindWrite, 9'd0, 9'd0, 24'hFFFFFF);
    send_item(KindWrite, 9'd0, 9'd1, 24'h000000);
    send_item(KindWrite, 9'd1, 9'd0, 24'hFF00FF);
    send_item(KindWrite, 9'd1, 9'd1, 24'h00FF00);
    query_at(0, 0);
    send_item(KindWrite, 9'd511, 9'd511, 24'hFFFFFF);
    send_item(KindWrite, 9'd510, 9'd510, 24'h000000);
    query_at(511, 511);
  endtask

  task automatic test_spare_register();
    wait_idle();
    cfg_write(CfgSpare, CfgDataW'($urandom()));
    query_at(0, 1);
  endtask

  task automatic test_outside_frame();
    set_config(3, 4, 4);
    send_item(KindWrite, 9'd300, 9'd200, 24'hC0A050);
    query_at(300, 200);
    query_at(4, 4);
    set_config(1, 512, 512);
    query_at(300, 200);
  endtask

  task automatic test_window_modes();
    int r, c;
    set_config(0, 512, 512);
    query_at(300, 200);
    set_config(2, 512, 512);
    for (r = 19; r <= 21; r++)
      for (c = 19; c <= 21; c++) send_item(KindWrite, 9'(r), 9'(c), 24'hFFFFFF);
    query_at(20, 20);
    set_config(31, 4, 4);
    query_at(1, 2);
  endtask

  task automatic test_frame_extremes();
    set_config(3, 0, 512);
    query_at(5, 5);
    set_config(3, 512, 0);
    query_at(5, 5);
    set_config(3, 1023, 1023);
    query_at(511, 0);
  endtask

  task automatic test_random_fixed();
    set_config(3, 512, 512);
    run_random(100, 16);
    set_config(1, 1, 1);
    run_random(60, 4);
    idle_pct = 0;
    set_config(5, 20, 13);
    run_random(100, 24);
    idle_pct = IdlePct;
    set_config(4, 9, 30);
    run_random(100, 34);
    set_config(31, 6, 5);
    run_random(60, 8);
  endtask

  task automatic test_random_configs();
    int          n;
    int unsigned ws, w, h;
    for (n = 0; n < 2; n++) begin
      ws = $urandom_range(31, 0);
      if (ws > 9) begin
        w = $urandom_range(16, 0);
        h = $urandom_range(16, 0);
      end else begin
        w = $urandom_range(1023, 0);
        h = $urandom_range(1023, 0);
      end
      set_config(ws, w, h);
      run_random(90, 32);
    end
  endtask

  task automatic report_mismatch(input string what, input rgb_pix_t want,
                                 input rgb_pix_t got);
    blur_mismatches++;
    if (blur_mismatches <= MaxReported)
      $display("%s: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d", what,
               want[2], want[1], want[0], got[2], got[1], got[0]);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0) begin
      blur_got = {blurred_red_o, blurred_green_o, blurred_blue_o};
      if (blur_expected.size() == 0) begin
        report_mismatch("unexpected result", '0, blur_got);
      end else begin
        blur_want = blur_expected.pop_front();
        if (result_valid_o !== 1'b1 || blur_got[2] !== blur_want[2] ||
            blur_got[1] !== blur_want[1] || blur_got[0] !== blur_want[0])
          report_mismatch("blur mismatch", blur_want, blur_got);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_spare_register();
    test_outside_frame();
    test_window_modes();
    test_frame_extremes();
    test_random_fixed();
    test_random_configs();
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (blur_mismatches == 0 && blur_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- box_blur_frame_query.f -----
+incdir+rtl
rtl/bbfq_pkg.sv
rtl/bbfq_div.sv
rtl/box_blur_frame_query.sv
tb/tb_top.sv
